FILE: rtl/sdva_pkg.sv
// Shared types, constants and the arctangent step table of the sky dome vertex attribute core.
package sdva_pkg;

  localparam int CoordBits = 16;
  localparam int UvBits    = 16;
  localparam int FracBits  = CoordBits - 2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgEmitNormal   = 2'd0,
    CfgEmitTangent  = 2'd1,
    CfgEmitTexcoord = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] norm_x;
    logic signed [CoordBits-1:0] norm_y;
    logic signed [CoordBits-1:0] norm_z;
    logic signed [CoordBits-1:0] tan_x;
    logic signed [CoordBits-1:0] tan_y;
    logic signed [CoordBits-1:0] tan_z;
    logic [UvBits-1:0]           tex_u;
    logic [UvBits-1:0]           tex_v;
    logic                        degenerate;
  } out_t;

  // Everything one vertex carries down the pipeline.
  typedef struct packed {
    logic               sx;
    logic               sy;
    logic               sz;
    logic               zle;
    logic               deg;
    logic               pole;
    logic [30:0]        a;
    logic [30:0]        b;
    logic [30:0]        c;
    logic [61:0]        sa;
    logic [61:0]        sb;
    logic [61:0]        sc;
    logic [63:0]        len_d;
    logic [63:0]        rho_d;
    logic [31:0]        len;
    logic [31:0]        rho;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [33:0] ang;
    logic [47:0]        rnx;
    logic [47:0]        rny;
    logic [47:0]        rnz;
    logic [47:0]        rtx;
    logic [47:0]        rty;
    logic [14:0]        qnx;
    logic [14:0]        qny;
    logic [14:0]        qnz;
    logic [14:0]        qtx;
    logic [14:0]        qty;
    logic [30:0]        phi;
    logic [61:0]        pa;
    logic [61:0]        pb;
    logic [63:0]        ru;
    logic [63:0]        rv;
    logic [30:0]        qu;
    logic [30:0]        qv;
  } pipe_t;

  // atan(2^-i) scaled so that a quarter turn is 2^30.
  function automatic logic [29:0] atan_step(input int i);
    logic [29:0] t;
    case (i)
      0:  t = 30'h20000000;
      1:  t = 30'h12E4051E;
      2:  t = 30'h09FB385B;
      3:  t = 30'h051111D4;
      4:  t = 30'h028B0D43;
      5:  t = 30'h0145D7E1;
      6:  t = 30'h00A2F61E;
      7:  t = 30'h00517C55;
      8:  t = 30'h0028BE53;
      9:  t = 30'h00145F2F;
      10: t = 30'h000A2F98;
      11: t = 30'h000517CC;
      12: t = 30'h00028BE6;
      13: t = 30'h000145F3;
      14: t = 30'h0000A2FA;
      15: t = 30'h0000517D;
      16: t = 30'h000028BE;
      17: t = 30'h0000145F;
      18: t = 30'h00000A30;
      19: t = 30'h00000518;
      20: t = 30'h0000028C;
      21: t = 30'h00000146;
      22: t = 30'h000000A3;
      23: t = 30'h00000051;
      24: t = 30'h00000029;
      25: t = 30'h00000014;
      26: t = 30'h0000000A;
      27: t = 30'h00000005;
      28: t = 30'h00000003;
      29: t = 30'h00000001;
      30: t = 30'h00000001;
      default: t = 30'h0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/sdva_sqrt_cell.sv
// One result bit of a digit-by-digit integer square root.
module sdva_sqrt_cell #(
  parameter int Bit = 0
) (
  input  logic [63:0] d_i,
  input  logic [31:0] r_i,
  output logic [63:0] d_o,
  output logic [31:0] r_o
);

  logic [65:0] trial;
  logic        ge;

  // d_i holds n - r^2; the bit is kept when (r + 2^Bit)^2 <= n.
  assign trial = (66'(r_i) << (Bit + 1)) + (66'(1) << (2 * Bit));
  assign ge    = 66'(d_i) >= trial;
  assign d_o   = ge ? 64'(66'(d_i) - trial) : d_i;
  assign r_o   = ge ? (r_i | (32'(1) << Bit)) : r_i;

endmodule

FILE: rtl/sdva_cordic_cell.sv
// One vectoring CORDIC rotation that drives y toward zero and sums the angle.
module sdva_cordic_cell #(
  parameter int Step = 0
) (
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  input  logic signed [33:0] ang_i,
  output logic signed [35:0] x_o,
  output logic signed [35:0] y_o,
  output logic signed [33:0] ang_o
);

  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic signed [33:0] t;

  assign dx = y_i >>> Step;
  assign dy = x_i >>> Step;
  assign t  = $signed(34'(sdva_pkg::atan_step(Step)));

  always_comb begin
    if (!y_i[35]) begin
      x_o   = x_i + dx;
      y_o   = y_i - dy;
      ang_o = ang_i + t;
    end else begin
      x_o   = x_i - dx;
      y_o   = y_i + dy;
      ang_o = ang_i - t;
    end
  end

endmodule

FILE: rtl/sdva_div_cell.sv
// One quotient bit of a restoring division.
module sdva_div_cell #(
  parameter int W     = 48,
  parameter int Shift = 0
) (
  input  logic [W-1:0] rem_i,
  input  logic [31:0]  den_i,
  output logic [W-1:0] rem_o,
  output logic         bit_o
);

  logic [W-1:0] dsh;

  assign dsh   = W'(den_i) << Shift;
  assign bit_o = rem_i >= dsh;
  assign rem_o = bit_o ? (rem_i - dsh) : rem_i;

endmodule

FILE: rtl/sky_dome_vertex_attributes_core.sv
// Top level of the sky dome vertex attribute core: a row of arithmetic cells.
//
// The core takes one vertex per clock while in_stall_o is low and returns its
// unit normal, azimuthal tangent and circular sky-map coordinate, one result
// item per vertex in input order. Throughput is one item per cycle while the row
// is not held. An accepted item passes through a prescale, a squaring and a
// summing stage, 32 square-root cells (one root bit each for the length and the
// planar radius), 31 CORDIC cells that find the polar angle while the first 15
// of them also divide out the normal and tangent, a clamp stage, a multiply stage
// and 31 division cells for the texture coordinate. All cells shift together; the
// row only holds when a finished item reaches its end and the two-entry output
// buffer is full, so new items keep entering while a result waits.
// Configuration writes take effect on items that reach the end of the row after
// the write; write only while the core is idle.
module sky_dome_vertex_attributes_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdva_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdva_pkg::out_t      out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic                cfg_wdata_i
);

  // Stage map of the row.
  localparam int SqrtFirst  = 3;
  localparam int SqrtSteps  = 32;
  localparam int CordFirst  = SqrtFirst + SqrtSteps;
  localparam int CordSteps  = 31;
  localparam int NdivSteps  = sdva_pkg::FracBits + 1;
  localparam int PhiStage   = CordFirst + CordSteps;
  localparam int MulStage   = PhiStage + 1;
  localparam int TdivFirst  = MulStage + 1;
  localparam int TdivSteps  = 31;
  localparam int Last       = TdivFirst + TdivSteps - 1;

  sdva_pkg::pipe_t pipe_q [0:Last];
  sdva_pkg::pipe_t pipe_d [0:Last];
  logic [Last:0]   v_q;

  logic en_norm_q, en_tan_q, en_tex_q;
  logic advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_norm_q <= 1'b1;
      en_tan_q  <= 1'b1;
      en_tex_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdva_pkg::CfgEmitNormal:   en_norm_q <= cfg_wdata_i;
        sdva_pkg::CfgEmitTangent:  en_tan_q  <= cfg_wdata_i;
        sdva_pkg::CfgEmitTexcoord: en_tex_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Prescale: absolute values shifted so the largest one reaches 2^30.
  logic [15:0] ax, ay, az, mx;
  logic [3:0]  msb;
  logic [4:0]  sh;

  always_comb begin
    ax = in_data_i.pos_x[15] ? 16'(-in_data_i.pos_x) : 16'(in_data_i.pos_x);
    ay = in_data_i.pos_y[15] ? 16'(-in_data_i.pos_y) : 16'(in_data_i.pos_y);
    az = in_data_i.pos_z[15] ? 16'(-in_data_i.pos_z) : 16'(in_data_i.pos_z);
    mx = (ax > ay) ? ax : ay;
    if (az > mx) begin
      mx = az;
    end
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mx[i]) begin
        msb = 4'(i);
      end
    end
    sh = 5'd30 - {1'b0, msb};
    pipe_d[0]      = '0;
    pipe_d[0].sx   = in_data_i.pos_x[15];
    pipe_d[0].sy   = in_data_i.pos_y[15];
    pipe_d[0].sz   = in_data_i.pos_z[15];
    pipe_d[0].zle  = in_data_i.pos_z[15] || (in_data_i.pos_z == '0);
    pipe_d[0].pole = (in_data_i.pos_x == '0) && (in_data_i.pos_y == '0);
    pipe_d[0].deg  = (in_data_i.pos_x == '0) && (in_data_i.pos_y == '0) &&
                     (in_data_i.pos_z == '0);
    pipe_d[0].a    = 31'(ax) << sh;
    pipe_d[0].b    = 31'(ay) << sh;
    pipe_d[0].c    = 31'(az) << sh;
  end

  always_comb begin
    pipe_d[1]    = pipe_q[0];
    pipe_d[1].sa = 62'(pipe_q[0].a) * 62'(pipe_q[0].a);
    pipe_d[1].sb = 62'(pipe_q[0].b) * 62'(pipe_q[0].b);
    pipe_d[1].sc = 62'(pipe_q[0].c) * 62'(pipe_q[0].c);
  end

  always_comb begin
    pipe_d[2]       = pipe_q[1];
    pipe_d[2].len_d = 64'(pipe_q[1].sa) + 64'(pipe_q[1].sb) + 64'(pipe_q[1].sc);
    pipe_d[2].rho_d = 64'(pipe_q[1].sa) + 64'(pipe_q[1].sb);
    pipe_d[2].len   = '0;
    pipe_d[2].rho   = '0;
  end

  // Square roots of the squared length and the squared planar radius.
  for (genvar s = SqrtFirst; s < SqrtFirst + SqrtSteps; s++) begin : g_sqrt
    localparam int K = SqrtSteps - 1 - (s - SqrtFirst);
    logic [63:0] ld, rd;
    logic [31:0] lr, rr;

    sdva_sqrt_cell #(.Bit(K)) u_len (
      .d_i(pipe_q[s-1].len_d), .r_i(pipe_q[s-1].len), .d_o(ld), .r_o(lr)
    );
    sdva_sqrt_cell #(.Bit(K)) u_rho (
      .d_i(pipe_q[s-1].rho_d), .r_i(pipe_q[s-1].rho), .d_o(rd), .r_o(rr)
    );

    always_comb begin
      pipe_d[s]       = pipe_q[s-1];
      pipe_d[s].len_d = ld;
      pipe_d[s].len   = lr;
      pipe_d[s].rho_d = rd;
      pipe_d[s].rho   = rr;
    end
  end

  // Polar angle by CORDIC; the first cells also divide out normal and tangent.
  for (genvar s = CordFirst; s < CordFirst + CordSteps; s++) begin : g_cord
    localparam int I = s - CordFirst;
    logic signed [35:0] xi, yi, xo, yo;
    logic signed [33:0] ai, ao;

    assign xi = (I == 0) ? $signed({5'b0, pipe_q[s-1].c})   : pipe_q[s-1].cx;
    assign yi = (I == 0) ? $signed({4'b0, pipe_q[s-1].rho}) : pipe_q[s-1].cy;
    assign ai = (I == 0) ? '0 : pipe_q[s-1].ang;

    sdva_cordic_cell #(.Step(I)) u_cell (
      .x_i(xi), .y_i(yi), .ang_i(ai), .x_o(xo), .y_o(yo), .ang_o(ao)
    );

    if (I < NdivSteps) begin : g_div
      localparam int Sh = NdivSteps - 1 - I;
      logic [47:0] nx_i, ny_i, nz_i, tx_i, ty_i;
      logic [47:0] nx_o, ny_o, nz_o, tx_o, ty_o;
      logic        bnx, bny, bnz, btx, bty;
      logic [31:0] lh, rh;

      assign lh = pipe_q[s-1].len >> 1;
      assign rh = pipe_q[s-1].rho >> 1;
      assign nx_i = (I == 0) ? (48'(pipe_q[s-1].a) << sdva_pkg::FracBits) + 48'(lh)
                             : pipe_q[s-1].rnx;
      assign ny_i = (I == 0) ? (48'(pipe_q[s-1].b) << sdva_pkg::FracBits) + 48'(lh)
                             : pipe_q[s-1].rny;
      assign nz_i = (I == 0) ? (48'(pipe_q[s-1].c) << sdva_pkg::FracBits) + 48'(lh)
                             : pipe_q[s-1].rnz;
      assign tx_i = (I == 0) ? (48'(pipe_q[s-1].b) << sdva_pkg::FracBits) + 48'(rh)
                             : pipe_q[s-1].rtx;
      assign ty_i = (I == 0) ? (48'(pipe_q[s-1].a) << sdva_pkg::FracBits) + 48'(rh)
                             : pipe_q[s-1].rty;

      sdva_div_cell #(.W(48), .Shift(Sh)) u_nx (
        .rem_i(nx_i), .den_i(pipe_q[s-1].len), .rem_o(nx_o), .bit_o(bnx));
      sdva_div_cell #(.W(48), .Shift(Sh)) u_ny (
        .rem_i(ny_i), .den_i(pipe_q[s-1].len), .rem_o(ny_o), .bit_o(bny));
      sdva_div_cell #(.W(48), .Shift(Sh)) u_nz (
        .rem_i(nz_i), .den_i(pipe_q[s-1].len), .rem_o(nz_o), .bit_o(bnz));
      sdva_div_cell #(.W(48), .Shift(Sh)) u_tx (
        .rem_i(tx_i), .den_i(pipe_q[s-1].rho), .rem_o(tx_o), .bit_o(btx));
      sdva_div_cell #(.W(48), .Shift(Sh)) u_ty (
        .rem_i(ty_i), .den_i(pipe_q[s-1].rho), .rem_o(ty_o), .bit_o(bty));

      always_comb begin
        pipe_d[s]     = pipe_q[s-1];
        pipe_d[s].cx  = xo;
        pipe_d[s].cy  = yo;
        pipe_d[s].ang = ao;
        pipe_d[s].rnx = nx_o;
        pipe_d[s].rny = ny_o;
        pipe_d[s].rnz = nz_o;
        pipe_d[s].rtx = tx_o;
        pipe_d[s].rty = ty_o;
        if (I == 0) begin
          pipe_d[s].qnx = '0;
          pipe_d[s].qny = '0;
          pipe_d[s].qnz = '0;
          pipe_d[s].qtx = '0;
          pipe_d[s].qty = '0;
        end
        pipe_d[s].qnx[Sh] = bnx;
        pipe_d[s].qny[Sh] = bny;
        pipe_d[s].qnz[Sh] = bnz;
        pipe_d[s].qtx[Sh] = btx;
        pipe_d[s].qty[Sh] = bty;
      end
    end else begin : g_nodiv
      always_comb begin
        pipe_d[s]     = pipe_q[s-1];
        pipe_d[s].cx  = xo;
        pipe_d[s].cy  = yo;
        pipe_d[s].ang = ao;
      end
    end
  end

  // Angle clamp and the special cases: lower hemisphere is a quarter turn, pole is zero.
  always_comb begin
    pipe_d[PhiStage] = pipe_q[PhiStage-1];
    if (pipe_q[PhiStage-1].zle) begin
      pipe_d[PhiStage].phi = 31'h4000_0000;
    end else if (pipe_q[PhiStage-1].pole || pipe_q[PhiStage-1].ang[33]) begin
      pipe_d[PhiStage].phi = '0;
    end else if (pipe_q[PhiStage-1].ang > 34'sh0_4000_0000) begin
      pipe_d[PhiStage].phi = 31'h4000_0000;
    end else begin
      pipe_d[PhiStage].phi = 31'(pipe_q[PhiStage-1].ang);
    end
  end

  always_comb begin
    pipe_d[MulStage]    = pipe_q[MulStage-1];
    pipe_d[MulStage].pa = 62'(pipe_q[MulStage-1].phi) * 62'(pipe_q[MulStage-1].a);
    pipe_d[MulStage].pb = 62'(pipe_q[MulStage-1].phi) * 62'(pipe_q[MulStage-1].b);
  end

  // Texture offsets: phi * A / rho and phi * B / rho, rounded.
  for (genvar s = TdivFirst; s < TdivFirst + TdivSteps; s++) begin : g_tdiv
    localparam int I  = s - TdivFirst;
    localparam int Sh = TdivSteps - 1 - I;
    logic [63:0] u_i, v_i, u_o, v_o;
    logic        bu, bv;
    logic [31:0] rh;

    assign rh  = pipe_q[s-1].rho >> 1;
    assign u_i = (I == 0) ? 64'(pipe_q[s-1].pa) + 64'(rh) : pipe_q[s-1].ru;
    assign v_i = (I == 0) ? 64'(pipe_q[s-1].pb) + 64'(rh) : pipe_q[s-1].rv;

    sdva_div_cell #(.W(64), .Shift(Sh)) u_u (
      .rem_i(u_i), .den_i(pipe_q[s-1].rho), .rem_o(u_o), .bit_o(bu));
    sdva_div_cell #(.W(64), .Shift(Sh)) u_v (
      .rem_i(v_i), .den_i(pipe_q[s-1].rho), .rem_o(v_o), .bit_o(bv));

    always_comb begin
      pipe_d[s]    = pipe_q[s-1];
      pipe_d[s].ru = u_o;
      pipe_d[s].rv = v_o;
      if (I == 0) begin
        pipe_d[s].qu = '0;
        pipe_d[s].qv = '0;
      end
      pipe_d[s].qu[Sh] = bu;
      pipe_d[s].qv[Sh] = bv;
    end
  end

  // Row registers: valid bits are reset, payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (advance) begin
      v_q <= {v_q[Last-1:0], in_valid_i};
    end
  end

  for (genvar s = 0; s <= Last; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (advance) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  // Result assembly from the last cell.
  function automatic logic [15:0] to_uv(input logic [31:0] w);
    logic [47:0] t;
    logic [16:0] q;
    t = {w, 16'b0} + 48'h0000_4000_0000;
    q = t[47:31];
    return (q > 17'h0FFFF) ? 16'hFFFF : q[15:0];
  endfunction

  sdva_pkg::pipe_t    fin;
  sdva_pkg::out_t     res;
  logic signed [32:0] tu, tv, wu, wv;

  assign fin = pipe_q[Last];

  always_comb begin
    res = '0;
    if (fin.pole) begin
      tu = $signed({2'b0, fin.phi});
      tv = '0;
    end else begin
      tu = fin.sx ? -$signed({2'b0, fin.qu}) : $signed({2'b0, fin.qu});
      tv = fin.sy ? -$signed({2'b0, fin.qv}) : $signed({2'b0, fin.qv});
    end
    wu = 33'sh0_4000_0000 + tu;
    wv = 33'sh0_4000_0000 + tv;
    if (fin.deg) begin
      res.degenerate = 1'b1;
    end else begin
      if (en_norm_q) begin
        res.norm_x = fin.sx ? -$signed(16'(fin.qnx)) : $signed(16'(fin.qnx));
        res.norm_y = fin.sy ? -$signed(16'(fin.qny)) : $signed(16'(fin.qny));
        res.norm_z = fin.sz ? -$signed(16'(fin.qnz)) : $signed(16'(fin.qnz));
      end
      if (en_norm_q && en_tan_q) begin
        if (fin.pole) begin
          res.tan_y = $signed(16'(1) << sdva_pkg::FracBits);
        end else begin
          res.tan_x = !fin.sy ? -$signed(16'(fin.qtx)) : $signed(16'(fin.qtx));
          res.tan_y = fin.sx ? -$signed(16'(fin.qty)) : $signed(16'(fin.qty));
        end
      end
      if (en_tex_q) begin
        res.tex_u = to_uv(wu[31:0]);
        res.tex_v = to_uv(wv[31:0]);
      end
    end
  end

  // Two-entry output buffer.
  sdva_pkg::out_t buf_q [2];
  logic [1:0]     cnt_q;
  logic           wr_ptr_q, rd_ptr_q;
  logic           push, pop;

  assign advance     = !(v_q[Last] && (cnt_q == 2'd2));
  assign in_stall_o  = !advance;
  assign push        = advance && v_q[Last];
  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

endmodule

FILE: rtl/sdva_checker.sv
// Port-level checks of the sky dome vertex attribute core and their bind.
module sdva_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input sdva_pkg::out_t out_data_o
);

  // A result held by stall stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed");

  // A degenerate vertex carries nothing but its flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.norm_x == '0 && out_data_o.norm_y == '0 && out_data_o.norm_z == '0 &&
      out_data_o.tan_x == '0 && out_data_o.tan_y == '0 &&
      out_data_o.tex_u == '0 && out_data_o.tex_v == '0)
    else $error("degenerate item has nonzero fields");

  // The tangent lies in the xy plane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tan_z == '0)
    else $error("tangent z is not zero");

  // The x and z normal components stay within one unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.norm_x <= 16'sd16384 && out_data_o.norm_x >= -16'sd16384 &&
      out_data_o.norm_z <= 16'sd16384 && out_data_o.norm_z >= -16'sd16384)
    else $error("normal component out of range");

endmodule

bind sky_dome_vertex_attributes_core sdva_checker u_sdva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
